[hdl/ntsp_pkg.sv]
// Shared types and constants of the TLV stream parser.
// No dependencies; the CSR interface, the design modules and the testbench import this package.
package ntsp_pkg;

   // Configuration register indexes
   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_NULL_TAG = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TERM_TAG = 1'b1;

   // Reset values of the configuration registers
   localparam logic [7:0] NULL_TAG_RESET = 8'h00;
   localparam logic [7:0] TERM_TAG_RESET = 8'hFE;

   // Length byte that announces a 16-bit big-endian length
   localparam logic [7:0] EXT_LEN_MARK = 8'hFF;

   // Role reported for each byte
   typedef enum logic [2:0] {
      ROLE_NULL = 3'd0,
      ROLE_TAG  = 3'd1,
      ROLE_SLEN = 3'd2,
      ROLE_LENH = 3'd3,
      ROLE_LENL = 3'd4,
      ROLE_VAL  = 3'd5,
      ROLE_TERM = 3'd6,
      ROLE_IGN  = 3'd7
   } role_type;

   // Parser phase, one-hot
   typedef enum logic [5:0] {
      PH_TAG  = 6'b000001,
      PH_LEN  = 6'b000010,
      PH_LENH = 6'b000100,
      PH_LENL = 6'b001000,
      PH_VAL  = 6'b010000,
      PH_DONE = 6'b100000
   } phase_type;

   // Configuration seen by the parser core
   typedef struct packed {
      logic [7:0] null_tag_code;
      logic [7:0] terminator_tag_code;
   } cfg_type;

   // One result transaction
   typedef struct packed {
      role_type    byte_role;
      logic [7:0]  tag_value;
      logic [15:0] record_length;
      logic [7:0]  value_byte;
      logic [15:0] value_index;
      logic        record_end;
      logic        stream_error;
      logic        buffer_done;
   } rsp_type;

endpackage

[hdl/ntsp_req_if.sv]
// Input channel of the TLV stream parser: one buffer byte per transaction.
// No dependencies.
interface ntsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       buffer_last;

   modport source (output valid, output data_byte, output buffer_last, input ready);
   modport sink (input valid, input data_byte, input buffer_last, output ready);
endinterface

[hdl/ntsp_rsp_if.sv]
// Result channel of the TLV stream parser: one classified byte per transaction.
// No dependencies.
interface ntsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  byte_role;
   logic [7:0]  tag_value;
   logic [15:0] record_length;
   logic [7:0]  value_byte;
   logic [15:0] value_index;
   logic        record_end;
   logic        stream_error;
   logic        buffer_done;

   modport source (output valid, output byte_role, output tag_value, output record_length,
                   output value_byte, output value_index, output record_end,
                   output stream_error, output buffer_done, input ready);
   modport sink (input valid, input byte_role, input tag_value, input record_length,
                 input value_byte, input value_index, input record_end,
                 input stream_error, input buffer_done, output ready);
endinterface

[hdl/ntsp_csr_if.sv]
// Configuration write channel of the TLV stream parser.
// Depends on ntsp_pkg for the register index width.
interface ntsp_csr_if
   import ntsp_pkg::*;
   ;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [7:0]           data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/ntsp_csr_regs.sv]
// Configuration registers: null tag code and terminator tag code.
// Depends on ntsp_pkg.
module ntsp_csr_regs
   import ntsp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [CSR_IDX_W-1:0] wr_index,
   input  logic [7:0]           wr_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write index
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_NULL_TAG: cfg_in.null_tag_code = wr_data;
            CSR_TERM_TAG: cfg_in.terminator_tag_code = wr_data;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.null_tag_code       <= NULL_TAG_RESET;
         cfg_ff.terminator_tag_code <= TERM_TAG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[hdl/ntsp_parse_core.sv]
// Parser state machine: classifies each accepted byte and updates the record state.
// Depends on ntsp_pkg.
module ntsp_parse_core
   import ntsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] data_byte,
   input  logic       buffer_last,
   input  cfg_type    cfg,
   output rsp_type    result
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  tag_ff, tag_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] remain_ff, remain_in;
   logic [15:0] pos_ff, pos_in;
   rsp_type     res;
   phase_type   phase_step;
   logic [15:0] full_len;

   // Classify the byte and work out the next record state
   always_comb begin
      res           = '0;
      res.byte_role = ROLE_IGN;
      phase_step    = phase_ff;
      tag_in        = tag_ff;
      len_in        = len_ff;
      remain_in     = remain_ff;
      pos_in        = pos_ff;
      full_len      = '0;
      case (phase_ff)
         PH_TAG: begin
            res.tag_value = data_byte;
            if (data_byte == cfg.null_tag_code) begin
               res.byte_role = ROLE_NULL;
            end else if (data_byte == cfg.terminator_tag_code) begin
               res.byte_role  = ROLE_TERM;
               res.record_end = 1'b1;
               phase_step     = PH_DONE;
            end else begin
               res.byte_role = ROLE_TAG;
               tag_in        = data_byte;
               len_in        = '0;
               phase_step    = PH_LEN;
            end
         end
         PH_LEN, PH_LENL: begin
            res.tag_value = tag_ff;
            if (phase_ff == PH_LEN) begin
               res.byte_role = ROLE_SLEN;
               full_len      = {8'h00, data_byte};
            end else begin
               res.byte_role = ROLE_LENL;
               full_len      = {len_ff[15:8], data_byte};
            end
            if (phase_ff == PH_LEN && data_byte == EXT_LEN_MARK) begin
               phase_step = PH_LENH;
            end else begin
               // Length is known: start the value or close an empty record
               len_in            = full_len;
               res.record_length = full_len;
               remain_in         = full_len;
               pos_in            = '0;
               if (full_len == 16'd0) begin
                  res.record_end = 1'b1;
                  phase_step     = PH_TAG;
               end else begin
                  phase_step = PH_VAL;
               end
            end
         end
         PH_LENH: begin
            res.byte_role = ROLE_LENH;
            res.tag_value = tag_ff;
            len_in        = {data_byte, 8'h00};
            phase_step    = PH_LENL;
         end
         PH_VAL: begin
            res.byte_role     = ROLE_VAL;
            res.tag_value     = tag_ff;
            res.record_length = len_ff;
            res.value_byte    = data_byte;
            res.value_index   = pos_ff;
            pos_in            = pos_ff + 16'd1;
            remain_in         = remain_ff - 16'd1;
            if (remain_ff == 16'd1) begin
               res.record_end = 1'b1;
               phase_step     = PH_TAG;
            end
         end
         PH_DONE: begin
            res.byte_role = ROLE_IGN;
         end
         default: begin
            res.byte_role = ROLE_IGN;
         end
      endcase

      // The buffer's last byte flags an open record and returns to idle
      res.buffer_done = buffer_last;
      phase_in        = phase_step;
      if (buffer_last) begin
         res.stream_error = (phase_step != PH_TAG) && (phase_step != PH_DONE);
         phase_in         = PH_TAG;
         tag_in           = '0;
         len_in           = '0;
         remain_in        = '0;
         pos_in           = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TAG;
         tag_ff    <= '0;
         len_ff    <= '0;
         remain_ff <= '0;
         pos_ff    <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         tag_ff    <= tag_in;
         len_ff    <= len_in;
         remain_ff <= remain_in;
         pos_ff    <= pos_in;
      end
   end

   assign result = res;

endmodule

[hdl/ntsp_rsp_reg.sv]
// Result register between the parser core and the result channel.
// Depends on ntsp_pkg.
module ntsp_rsp_reg
   import ntsp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  rsp_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   // A new result may load when the register is empty or being drained
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = (in_valid && in_ready) || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[hdl/nfc_tlv_stream_parser.sv]
// Top level of the TLV stream parser for a Type 2 tag memory buffer.
// Depends on ntsp_pkg, the channel interfaces, ntsp_csr_regs, ntsp_parse_core, ntsp_rsp_reg.

// The parser takes one buffer byte per clock and returns exactly one result
// transaction per byte, in the cycle after the byte is accepted; the parser core
// classifies each byte combinationally into the one result register, so a byte can
// be accepted every cycle as long as the result side keeps up.
// Configuration writes are always accepted and take effect on the next byte.
module nfc_tlv_stream_parser
   import ntsp_pkg::*;
(
   input logic         clock,
   input logic         reset,
   ntsp_req_if.sink    req_bus,
   ntsp_rsp_if.source  rsp_bus,
   ntsp_csr_if.sink    csr_bus
);

   cfg_type cfg;
   rsp_type core_result;
   rsp_type rsp_data;
   logic    req_accept;
   logic    in_ready;

   // Configuration registers
   assign csr_bus.ready = 1'b1;

   ntsp_csr_regs u_csr_regs (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_bus.valid),
      .wr_index (csr_bus.index),
      .wr_data  (csr_bus.data),
      .cfg      (cfg)
   );

   // Byte classification and record state
   assign req_bus.ready = in_ready;
   assign req_accept    = req_bus.valid && in_ready;

   ntsp_parse_core u_parse_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .data_byte   (req_bus.data_byte),
      .buffer_last (req_bus.buffer_last),
      .cfg         (cfg),
      .result      (core_result)
   );

   // Result register
   ntsp_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (in_ready),
      .in_data   (core_result),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (rsp_data)
   );

   assign rsp_bus.byte_role     = rsp_data.byte_role;
   assign rsp_bus.tag_value     = rsp_data.tag_value;
   assign rsp_bus.record_length = rsp_data.record_length;
   assign rsp_bus.value_byte    = rsp_data.value_byte;
   assign rsp_bus.value_index   = rsp_data.value_index;
   assign rsp_bus.record_end    = rsp_data.record_end;
   assign rsp_bus.stream_error  = rsp_data.stream_error;
   assign rsp_bus.buffer_done   = rsp_data.buffer_done;

`ifndef SYNTHESIS
   // An error is only reported on the byte that closes the buffer.
   a_error_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.stream_error |-> rsp_bus.buffer_done)
      else $error("stream_error without buffer_done");

   // The last value byte of a record sits at index length minus one.
   a_value_end_index: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.record_end && (rsp_bus.byte_role == ROLE_VAL)
      |-> (rsp_bus.value_index == rsp_bus.record_length - 16'd1))
      else $error("record end at wrong value index");

   // A byte accepted into an empty result register appears in the next cycle.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready && !rsp_bus.valid |=> rsp_bus.valid)
      else $error("accepted byte produced no result");
`endif

endmodule

[bench/tb_nfc_tlv_stream_parser.sv]
// Self-checking testbench for the TLV stream parser of a Type 2 tag memory buffer.
// Depends on ntsp_pkg, the three channel interfaces and the nfc_tlv_stream_parser top level.
module tb_nfc_tlv_stream_parser;
   import ntsp_pkg::*;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int N_SETTINGS     = 6;
   localparam int RAND_PER_PHASE = 80;
   localparam int CHUNK_BYTES    = 40;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } tlv_byte_type;

   typedef logic [7:0] byte_list_type[$];

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Values driven onto the channels; every input is known from time zero.
   logic                 req_valid = 1'b0;
   logic [7:0]           req_data  = 8'h00;
   logic                 req_last  = 1'b0;
   logic                 rsp_ready = 1'b0;
   logic                 csr_valid = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_NULL_TAG;
   logic [7:0]           csr_data  = 8'h00;

   ntsp_req_if req_bus ();
   ntsp_rsp_if rsp_bus ();
   ntsp_csr_if csr_bus ();

   assign req_bus.valid       = req_valid;
   assign req_bus.data_byte   = req_data;
   assign req_bus.buffer_last = req_last;
   assign rsp_bus.ready       = rsp_ready;
   assign csr_bus.valid       = csr_valid;
   assign csr_bus.index       = csr_index;
   assign csr_bus.data        = csr_data;

   nfc_tlv_stream_parser dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #5 clock = ~clock;

   // Bytes waiting to be sent and classifications waiting to come back.
   tlv_byte_type tag_mem_q[$];
   rsp_type      classified_q[$];

   // Handshake flags sampled at the rising edge, used at the falling edge.
   bit req_fire = 1'b0;
   bit rsp_fire = 1'b0;
   int req_pace = 0;
   int rsp_pace = 0;
   int gap_left = 0;
   int stall_left = 0;

   int error_count = 0;
   int cycle_count = 0;
   int n_bytes = 0;
   int n_buffers = 0;
   int n_rec_ends = 0;
   int n_truncated = 0;

   // Mirror of the configuration registers.
   logic [7:0] null_code = NULL_TAG_RESET;
   logic [7:0] term_code = TERM_TAG_RESET;

   // Parser state as predicted by the testbench.
   phase_type   ph_state = PH_TAG;
   logic [7:0]  cur_tag = 8'h00;
   logic [15:0] len_reg = 16'h0000;
   logic [15:0] left_cnt = 16'h0000;
   logic [15:0] val_pos = 16'h0000;
   logic        term_seen = 1'b0;

   function automatic void clear_parser();
      ph_state  = PH_TAG;
      cur_tag   = 8'h00;
      len_reg   = 16'h0000;
      left_cnt  = 16'h0000;
      val_pos   = 16'h0000;
      term_seen = 1'b0;
   endfunction

   // Once the length is known, either close a zero-length record or enter the value.
   function automatic logic open_value();
      val_pos  = 16'h0000;
      left_cnt = len_reg;
      if (len_reg == 16'h0000) begin
         ph_state = PH_TAG;
         return 1'b1;
      end
      ph_state = PH_VAL;
      return 1'b0;
   endfunction

   // Classify one buffer byte and advance the predicted parser state.
   function automatic rsp_type classify_byte(input logic [7:0] b, input logic last);
      rsp_type r;
      r = '0;
      r.byte_role = ROLE_IGN;
      case (ph_state)
         PH_TAG: begin
            // The null code wins when both codes are equal.
            if (b == null_code) begin
               r.byte_role = ROLE_NULL;
               r.tag_value = b;
            end else if (b == term_code) begin
               r.byte_role  = ROLE_TERM;
               r.tag_value  = b;
               r.record_end = 1'b1;
               term_seen    = 1'b1;
               ph_state     = PH_DONE;
            end else begin
               r.byte_role = ROLE_TAG;
               r.tag_value = b;
               cur_tag     = b;
               len_reg     = 16'h0000;
               ph_state    = PH_LEN;
            end
         end
         PH_LEN: begin
            r.byte_role = ROLE_SLEN;
            r.tag_value = cur_tag;
            if (b == EXT_LEN_MARK) begin
               ph_state = PH_LENH;
            end else begin
               len_reg         = {8'h00, b};
               r.record_length = len_reg;
               r.record_end    = open_value();
            end
         end
         PH_LENH: begin
            r.byte_role = ROLE_LENH;
            r.tag_value = cur_tag;
            len_reg     = {b, 8'h00};
            ph_state    = PH_LENL;
         end
         PH_LENL: begin
            r.byte_role     = ROLE_LENL;
            r.tag_value     = cur_tag;
            len_reg         = len_reg | {8'h00, b};
            r.record_length = len_reg;
            r.record_end    = open_value();
         end
         PH_VAL: begin
            r.byte_role     = ROLE_VAL;
            r.tag_value     = cur_tag;
            r.record_length = len_reg;
            r.value_byte    = b;
            r.value_index   = val_pos;
            val_pos         = val_pos + 16'd1;
            left_cnt        = left_cnt - 16'd1;
            if (left_cnt == 16'h0000) begin
               r.record_end = 1'b1;
               ph_state     = PH_TAG;
            end
         end
         default: begin
         end
      endcase
      // The buffer's last byte reports an open record and returns the parser to idle.
      if (last) begin
         r.stream_error = (ph_state != PH_TAG) && (ph_state != PH_DONE);
         clear_parser();
      end
      r.buffer_done = last;
      return r;
   endfunction

   function automatic void compare_field(input string name, input logic [15:0] want,
                                         input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endfunction

   function automatic void check_result(input rsp_type want);
      compare_field("byte_role", 16'(want.byte_role), 16'(rsp_bus.byte_role));
      compare_field("tag_value", 16'(want.tag_value), 16'(rsp_bus.tag_value));
      compare_field("record_length", want.record_length, rsp_bus.record_length);
      compare_field("value_byte", 16'(want.value_byte), 16'(rsp_bus.value_byte));
      compare_field("value_index", want.value_index, rsp_bus.value_index);
      compare_field("record_end", 16'(want.record_end), 16'(rsp_bus.record_end));
      compare_field("stream_error", 16'(want.stream_error), 16'(rsp_bus.stream_error));
      compare_field("buffer_done", 16'(want.buffer_done), 16'(rsp_bus.buffer_done));
      if (want.record_end) n_rec_ends++;
      if (want.stream_error) n_truncated++;
      if (want.buffer_done) n_buffers++;
   endfunction

   // Pace 0 never idles, pace 1 idles now and then, pace 2 idles on most transactions.
   function automatic int draw_wait(input int pace);
      case (pace)
         0: return 0;
         1: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0;
         default: return $urandom_range(0, 12);
      endcase
   endfunction

   // Rising edge: track register writes, predict accepted bytes and check results.
   always @(posedge clock) begin
      req_fire = req_valid && req_bus.ready;
      rsp_fire = rsp_bus.valid && rsp_ready;
      if (reset) begin
         clear_parser();
         null_code = NULL_TAG_RESET;
         term_code = TERM_TAG_RESET;
      end else begin
         if (csr_valid && csr_bus.ready) begin
            if (csr_index == CSR_NULL_TAG) begin
               null_code = csr_data;
            end else if (csr_index == CSR_TERM_TAG) begin
               term_code = csr_data;
            end
         end
         if (req_fire) begin
            classified_q.push_back(classify_byte(req_data, req_last));
            n_bytes++;
         end
         if (rsp_fire) begin
            if (classified_q.size() == 0) begin
               $error("result transaction arrived with no byte outstanding");
               error_count++;
            end else begin
               check_result(classified_q.pop_front());
            end
         end
      end
   end

   // Byte driver: holds a byte until it is taken, then waits a drawn gap.
   always @(negedge clock) begin
      if (req_valid && !req_fire) begin
         // Transaction still pending; keep everything stable.
      end else begin
         if (req_fire) gap_left = draw_wait(req_pace);
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left--;
         end else if (tag_mem_q.size() != 0) begin
            tlv_byte_type it;
            it = tag_mem_q.pop_front();
            req_data  <= it.data;
            req_last  <= it.last;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: stalls for a drawn wait after each transaction.
   always @(negedge clock) begin
      if (rsp_fire) stall_left = draw_wait(rsp_pace);
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Cycle limit %0d hit with %0d bytes unsent and %0d results outstanding",
                  CYCLE_LIMIT, tag_mem_q.size(), classified_q.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic queue_buffer(input byte_list_type bytes);
      tlv_byte_type it;
      for (int i = 0; i < bytes.size(); i++) begin
         it.data = bytes[i];
         it.last = (i == bytes.size() - 1);
         tag_mem_q.push_back(it);
      end
   endtask

   // Build one random buffer: mostly well-formed records, some cut short, some noise.
   // The count returned leaves out bytes that trail a terminator.
   task automatic build_buffer(input logic [7:0] nul, input logic [7:0] trm, output int count);
      byte_list_type bytes;
      int shape, n_rec, len, nval, tail, useful, cut;
      logic [7:0] tg, hi, lo;
      bit stop;
      stop = 1'b0;
      tail = 0;
      shape = $urandom_range(0, 9);
      if (shape == 9) begin
         // Noise, salted with the configured codes and the extended-length marker.
         repeat ($urandom_range(1, 12)) begin
            case ($urandom_range(0, 5))
               0: bytes.push_back(nul);
               1: bytes.push_back(trm);
               2: bytes.push_back(EXT_LEN_MARK);
               default: bytes.push_back(8'($urandom));
            endcase
         end
      end else begin
         n_rec = $urandom_range(1, 4);
         for (int r = 0; r < n_rec && !stop; r++) begin
            if ($urandom_range(0, 4) == 0) bytes.push_back(nul);
            tg = nul;
            while (tg == nul || tg == trm) tg = 8'($urandom);
            bytes.push_back(tg);
            case ($urandom_range(0, 15))
               9, 10: begin
                  len = $urandom_range(9, 40);
                  bytes.push_back(8'(len));
               end
               11, 12, 13, 14: begin
                  len = $urandom_range(0, 8);
                  bytes.push_back(EXT_LEN_MARK);
                  bytes.push_back(8'h00);
                  bytes.push_back(8'(len));
               end
               15: begin
                  hi = 8'($urandom);
                  lo = 8'($urandom);
                  len = {hi, lo};
                  bytes.push_back(EXT_LEN_MARK);
                  bytes.push_back(hi);
                  bytes.push_back(lo);
               end
               default: begin
                  len = $urandom_range(0, 8);
                  bytes.push_back(8'(len));
               end
            endcase
            // Long values are never sent whole, so such a buffer ends inside the record.
            nval = (len > CHUNK_BYTES) ? $urandom_range(0, 6) : len;
            repeat (nval) bytes.push_back(8'($urandom));
            if (nval < len) stop = 1'b1;
         end
         if (!stop && $urandom_range(0, 1) == 1) begin
            bytes.push_back(trm);
            tail = $urandom_range(0, 3);
            repeat (tail) bytes.push_back(8'($urandom));
         end
      end
      useful = bytes.size() - tail;
      if (shape == 7 || shape == 8) begin
         cut = $urandom_range(1, bytes.size());
         while (bytes.size() > cut) void'(bytes.pop_back());
      end
      count = (bytes.size() < useful) ? bytes.size() : useful;
      queue_buffer(bytes);
   endtask

   task automatic wait_idle();
      while (tag_mem_q.size() != 0 || req_valid || classified_q.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Stimulus: directed buffers under reset values, then random buffers over six settings.
   initial begin
      int rand_cnt, chunk, n;
      logic [7:0] gen_null, gen_term;
      byte_list_type dir;
      gen_null = NULL_TAG_RESET;
      gen_term = TERM_TAG_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int ph = 0; ph < N_SETTINGS; ph++) begin
         if (ph > 0) begin
            case (ph)
               1: begin
                  gen_null = 8'hFF;
                  gen_term = 8'h00;
               end
               2: begin
                  gen_null = 8'($urandom);
                  gen_term = gen_null;
               end
               3: begin
                  gen_null = 8'($urandom);
                  gen_term = 8'($urandom);
               end
               4: begin
                  gen_null = 8'h00;
                  gen_term = 8'hFF;
               end
               default: begin
                  gen_null = NULL_TAG_RESET;
                  gen_term = TERM_TAG_RESET;
               end
            endcase
            write_reg(CSR_NULL_TAG, gen_null);
            write_reg(CSR_TERM_TAG, gen_term);
            @(posedge clock);
         end else begin
            // Padding, short records, a zero-length record, extended lengths
            // including zero, the terminator and bytes ignored after it.
            req_pace = 0;
            rsp_pace = 0;
            dir = '{8'h00, 8'h03, 8'h02, 8'hAA, 8'h55, 8'h10, 8'h00,
                    8'h01, EXT_LEN_MARK, 8'h00, 8'h03, 8'h00, 8'h80, 8'hFF,
                    8'h30, EXT_LEN_MARK, 8'h00, 8'h00, TERM_TAG_RESET, 8'h77, 8'hFF};
            queue_buffer(dir);
            // Largest extended length, buffer ending on its low byte.
            dir = '{8'hFF, EXT_LEN_MARK, 8'hFF, 8'hFF};
            queue_buffer(dir);
            // Buffer ending right after a tag.
            dir = '{8'h7F};
            queue_buffer(dir);
            while (tag_mem_q.size() != 0) @(posedge clock);
         end

         rand_cnt = 0;
         while (rand_cnt < RAND_PER_PHASE) begin
            req_pace = $urandom_range(0, 2);
            rsp_pace = $urandom_range(0, 2);
            chunk = 0;
            while (chunk < CHUNK_BYTES) begin
               build_buffer(gen_null, gen_term, n);
               chunk += n;
            end
            rand_cnt += chunk;
            while (tag_mem_q.size() != 0) @(posedge clock);
         end
         wait_idle();
      end

      if (classified_q.size() != 0) begin
         $error("%0d expected results never arrived", classified_q.size());
         error_count++;
      end
      $display("Run covered %0d bytes in %0d buffers under %0d tag-code settings.",
               n_bytes, n_buffers, N_SETTINGS);
      $display("Records closed: %0d; buffers ending inside a record: %0d.",
               n_rec_ends, n_truncated);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
